// ===== hw/rtl/ptps_pkg.sv =====
// ============================================================================
// ptps_pkg: shared types and constants of the process table scheduler
// Field widths, action and status codes, and the command and status bundles
// that join the controller to the datapath.
// ============================================================================
package ptps_pkg;

    localparam int NUM_SLOTS_DEF = 64;

    localparam int ACTION_W = 3;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int PID_W    = 31;
    localparam int PRIO_W   = 7;
    localparam int MODE_W   = 2;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PRI = 1'd1;

    localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOC     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SET_STATE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SET_PRIO  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SCHEDULE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_UNUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SLEEPING  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RUNNABLE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RUNNING   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd5;

    localparam logic [MODE_W-1:0] MODE_RR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FC   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_PRIO;
    localparam logic [PRIO_W-1:0] DEF_PRI_RST  = 7'd60;
    localparam logic [PRIO_W-1:0] PRIO_MAX     = 7'd100;
    localparam logic [3:0]        NICE_DEFAULT = 4'd5;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [31:0]         pid;
        logic [PRIO_W-1:0]   base;
        logic [31:0]         run;
        logic [31:0]         sleep;
        logic [31:0]         disp;
        logic [31:0]         create;
    } t_slot_rec;

    typedef struct packed {
        logic load;
        logic rd;
        logic rd_best;
        logic eval;
        logic pick;
        logic next;
        logic div_start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic start_walk;
        logic need_div;
        logic div_done;
        logic walk_end;
        logic scan;
        logic have_best;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/ptps_div.sv =====
// ============================================================================
// ptps_div: niceness divider
// Computes (sleep * 10) / (sleep + run) by restoring division, one quotient
// bit per cycle; the quotient never exceeds ten.
// ============================================================================
module ptps_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_sleep,
    input  logic [31:0] i_run,
    output logic        o_done,
    output logic [3:0]  o_quot
);
    import ptps_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    logic [35:0] r_rem;
    logic [32:0] r_den;
    logic [3:0]  r_quot;
    logic [35:0] trial;

    assign trial = 36'(r_den) << r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
            r_rem  <= 36'd0;
            r_den  <= 33'd0;
            r_quot <= 4'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= 2'd3;
            r_rem  <= {1'b0, i_sleep, 3'b000} + {3'b000, i_sleep, 1'b0};
            r_den  <= {1'b0, i_sleep} + {1'b0, i_run};
            r_quot <= 4'd0;
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                r_rem          <= r_rem - trial;
                r_quot[r_step] <= 1'b1;
            end
            if (r_step == 2'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_step <= r_step - 2'd1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/ptps_dp.sv =====
// ============================================================================
// ptps_dp: scheduler datapath
// Slot memory with valid bits, global counters, per-slot update and
// selection logic, niceness divider and the result register.
// ============================================================================
module ptps_dp #(
    parameter int NUM_SLOTS = ptps_pkg::NUM_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ptps_pkg::t_cmd                      i_cmd,
    output ptps_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_we,
    input  logic [ptps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ptps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [ptps_pkg::IN_DATA_W-1:0]      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ptps_pkg::OUT_DATA_W-1:0]     o_out_data
);
    import ptps_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W + 1)'(NUM_SLOTS);

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    logic [ACTION_W-1:0] r_action;
    logic [SLOT_W-1:0]   r_sidx;
    logic [STATUS_W-1:0] r_nstat;
    logic [PID_W-1:0]    r_tpid;
    logic [PRIO_W-1:0]   r_nprio;

    logic [MODE_W-1:0]   r_mode;
    logic [PRIO_W-1:0]   r_def_prio;
    logic [31:0]         r_tick_count;
    logic [31:0]         r_next_pid;
    logic [IDX_W-1:0]    r_rr;
    logic [IDX_W-1:0]    r_cnt;

    t_slot_rec           r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;
    t_slot_rec           r_rd_raw;
    logic                r_rd_valid;
    logic [IDX_W-1:0]    r_addr;

    logic                r_have_best;
    logic [IDX_W-1:0]    r_best_idx;
    logic [PRIO_W-1:0]   r_best_dp;
    logic [31:0]         r_best_disp;
    logic [31:0]         r_best_create;

    logic                r_ok;
    logic [SLOT_W-1:0]   r_slot;
    logic [PID_W-1:0]    r_pid;
    logic [PRIO_W-1:0]   r_oldp;
    logic                r_yield;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_slot_rec           cur;
    t_slot_rec           wrec;
    logic                wr_en;
    logic                hit;
    logic                runnable;
    logic                need_div;
    logic                better;
    logic                div_done;
    logic [3:0]          div_quot;
    logic [3:0]          nice;
    logic [7:0]          prio_sum;
    logic [7:0]          prio_diff;
    logic [PRIO_W-1:0]   dyn;
    logic [IDX_W:0]      rr_sum;
    logic [IDX_W-1:0]    walk_addr;
    logic [IDX_W-1:0]    rd_addr;
    logic                sidx_ok;
    logic                is_rr;

    assign cur      = r_rd_valid ? r_rd_raw : '0;
    assign runnable = (cur.status == ST_RUNNABLE);
    assign sidx_ok  = (32'(r_sidx) < 32'(NUM_SLOTS));
    assign is_rr    = (r_action == ACT_SCHEDULE) && (r_mode == MODE_RR);

    // Round robin starts one past the last pick and wraps around the table.
    assign rr_sum = {1'b0, r_rr} + {1'b0, r_cnt} + (IDX_W + 1)'(1);

    always_comb begin
        if (r_action == ACT_SET_STATE) begin
            walk_addr = IDX_W'(r_sidx);
        end else if (is_rr) begin
            walk_addr = (rr_sum >= SLOTS_EXT) ? IDX_W'(rr_sum - SLOTS_EXT) : IDX_W'(rr_sum);
        end else begin
            walk_addr = r_cnt;
        end
        rd_addr = i_cmd.rd_best ? r_best_idx : walk_addr;
    end

    // Dynamic priority: clamp(base - niceness + 5, 0, 100).
    assign need_div = (r_action == ACT_SCHEDULE) && (r_mode == MODE_PRIO) && runnable &&
                      (cur.disp != 32'd0) && ((cur.run | cur.sleep) != 32'd0);
    assign nice      = need_div ? div_quot : NICE_DEFAULT;
    assign prio_sum  = {1'b0, cur.base} + 8'd5;
    assign prio_diff = prio_sum - {4'd0, nice};
    always_comb begin
        if (prio_sum < {4'd0, nice}) begin
            dyn = '0;
        end else if (prio_diff > {1'b0, PRIO_MAX}) begin
            dyn = PRIO_MAX;
        end else begin
            dyn = prio_diff[PRIO_W-1:0];
        end
    end

    always_comb begin
        if (!r_have_best) begin
            better = 1'b1;
        end else if (r_mode == MODE_FC) begin
            better = (r_best_create > cur.create);
        end else begin
            better = (dyn < r_best_dp) ||
                     ((dyn == r_best_dp) &&
                      ((cur.disp < r_best_disp) ||
                       ((cur.disp == r_best_disp) && (cur.create < r_best_create))));
        end
    end

    always_comb begin
        wrec  = cur;
        wr_en = 1'b0;
        hit   = 1'b0;
        case (r_action)
            ACT_ALLOC:    hit = (cur.status == ST_UNUSED);
            ACT_SET_PRIO: hit = (cur.status != ST_UNUSED) && (cur.pid == {1'b0, r_tpid});
            ACT_SCHEDULE: hit = is_rr && runnable;
            default:      hit = 1'b0;
        endcase
        if (i_cmd.pick) begin
            wrec.disp   = sat_inc(cur.disp);
            wrec.status = ST_RUNNING;
            if (r_mode == MODE_PRIO) begin
                wrec.run   = 32'd0;
                wrec.sleep = 32'd0;
            end
            wr_en = 1'b1;
        end else if (i_cmd.eval) begin
            case (r_action)
                ACT_TICK: begin
                    if (cur.status == ST_RUNNING) begin
                        wrec.run = sat_inc(cur.run);
                    end else if (cur.status == ST_SLEEPING) begin
                        wrec.sleep = sat_inc(cur.sleep);
                    end
                    wr_en = 1'b1;
                end
                ACT_ALLOC: begin
                    wrec.status = ST_ALLOCATED;
                    wrec.pid    = r_next_pid;
                    wrec.base   = r_def_prio;
                    wrec.run    = 32'd0;
                    wrec.sleep  = 32'd0;
                    wrec.disp   = 32'd0;
                    wrec.create = r_tick_count;
                    wr_en       = hit;
                end
                ACT_SET_STATE: begin
                    wrec.status = r_nstat;
                    wr_en       = 1'b1;
                end
                ACT_SET_PRIO: begin
                    wrec.base  = r_nprio;
                    wrec.run   = 32'd0;
                    wrec.sleep = 32'd0;
                    wr_en      = hit;
                end
                ACT_SCHEDULE: begin
                    wrec.disp   = sat_inc(cur.disp);
                    wrec.status = ST_RUNNING;
                    wr_en       = hit;
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    // Slot memory: registered read, write back to the address last read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd || i_cmd.rd_best) begin
            r_rd_raw <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_addr] <= wrec;
        end
    end

    // A slot that was never written reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_addr     <= '0;
        end else begin
            if (i_cmd.rd || i_cmd.rd_best) begin
                r_rd_valid <= r_valid[rd_addr];
                r_addr     <= rd_addr;
            end
            if (wr_en) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_RESET;
            r_def_prio <= DEF_PRI_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCHED_MODE:  r_mode     <= i_cfg_data[MODE_W-1:0];
                REG_DEFAULT_PRI: r_def_prio <= i_cfg_data[PRIO_W-1:0];
                default:         r_mode     <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action      <= ACT_TICK;
            r_sidx        <= '0;
            r_nstat       <= ST_UNUSED;
            r_tpid        <= '0;
            r_nprio       <= '0;
            r_tick_count  <= 32'd0;
            r_next_pid    <= 32'd1;
            r_rr          <= LAST_IDX;
            r_cnt         <= '0;
            r_have_best   <= 1'b0;
            r_best_idx    <= '0;
            r_best_dp     <= '0;
            r_best_disp   <= 32'd0;
            r_best_create <= 32'd0;
            r_ok          <= 1'b0;
            r_slot        <= '0;
            r_pid         <= '0;
            r_oldp        <= '0;
            r_yield       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_data    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_action    <= i_in_data[2:0];
                r_sidx      <= i_in_data[8:3];
                r_nstat     <= i_in_data[11:9];
                r_tpid      <= i_in_data[42:12];
                r_nprio     <= i_in_data[49:43];
                r_cnt       <= '0;
                r_have_best <= 1'b0;
                r_ok        <= (i_in_data[2:0] == ACT_TICK);
                r_slot      <= '0;
                r_pid       <= '0;
                r_oldp      <= '0;
                r_yield     <= 1'b0;
                if (i_in_data[2:0] == ACT_TICK) begin
                    r_tick_count <= sat_inc(r_tick_count);
                end
            end
            if (i_cmd.next) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
            if (i_cmd.eval) begin
                case (r_action)
                    ACT_ALLOC: begin
                        if (hit) begin
                            r_next_pid <= sat_inc(r_next_pid);
                            r_ok       <= 1'b1;
                            r_slot     <= SLOT_W'(r_addr);
                            r_pid      <= r_next_pid[PID_W-1:0];
                        end
                    end
                    ACT_SET_STATE: r_ok <= 1'b1;
                    ACT_SET_PRIO: begin
                        if (hit) begin
                            r_ok    <= 1'b1;
                            r_oldp  <= cur.base;
                            r_yield <= (cur.base > r_nprio);
                        end
                    end
                    ACT_SCHEDULE: begin
                        if (hit) begin
                            r_rr   <= r_addr;
                            r_ok   <= 1'b1;
                            r_slot <= SLOT_W'(r_addr);
                            r_pid  <= cur.pid[PID_W-1:0];
                        end else if (!is_rr && runnable && better) begin
                            r_have_best   <= 1'b1;
                            r_best_idx    <= r_addr;
                            r_best_dp     <= dyn;
                            r_best_disp   <= cur.disp;
                            r_best_create <= cur.create;
                        end
                    end
                    default: r_ok <= r_ok;
                endcase
            end
            if (i_cmd.pick) begin
                r_ok   <= 1'b1;
                r_slot <= SLOT_W'(r_addr);
                r_pid  <= cur.pid[PID_W-1:0];
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {2'b00, r_yield, r_oldp, r_pid, r_slot, r_ok};
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    ptps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_sleep (cur.sleep),
        .i_run   (cur.run),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        o_stat.start_walk = (r_action == ACT_TICK) || (r_action == ACT_ALLOC) ||
                            ((r_action == ACT_SET_STATE) && sidx_ok) ||
                            ((r_action == ACT_SET_PRIO) && (r_nprio <= PRIO_MAX)) ||
                            ((r_action == ACT_SCHEDULE) && (r_mode != MODE_OFF));
        o_stat.need_div   = need_div;
        o_stat.div_done   = div_done;
        o_stat.walk_end   = hit || (r_action == ACT_SET_STATE) || (r_cnt == LAST_IDX);
        o_stat.scan       = (r_action == ACT_SCHEDULE) && !is_rr;
        o_stat.have_best  = r_have_best;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hw/rtl/ptps_ctrl.sv =====
// ============================================================================
// ptps_ctrl: scheduler controller
// Sequences one action: latch, walk the slot table, optional divide per slot,
// scan-mode update of the chosen slot, and hand-off to the result register.
// ============================================================================
module ptps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ptps_pkg::t_stat  i_stat,
    output ptps_pkg::t_cmd   o_cmd
);
    import ptps_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_FIX_RD = 3'd5;
    localparam logic [2:0] S_FIX_EV = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       do_eval;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        do_eval = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START:  n_state = i_stat.start_walk ? S_READ : S_DONE;
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    do_eval = 1'b1;
                end
            end
            S_DIV:    do_eval = i_stat.div_done;
            S_FIX_RD: begin
                if (i_stat.have_best) begin
                    o_cmd.rd_best = 1'b1;
                    n_state       = S_FIX_EV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FIX_EV: begin
                o_cmd.pick = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // Scan modes finish the walk before touching the chosen slot.
        if (do_eval) begin
            o_cmd.eval = 1'b1;
            if (i_stat.walk_end) begin
                n_state = i_stat.scan ? S_FIX_RD : S_DONE;
            end else begin
                o_cmd.next = 1'b1;
                n_state    = S_READ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/process_table_priority_scheduler_core.sv =====
// ============================================================================
// process_table_priority_scheduler_core: process table scheduler top level
// Round-robin, first-come and dynamic-priority selection over a slot table.
// ============================================================================
// One transaction carries one action and yields one result transaction. The
// block works on one action at a time by walking the slot memory, which has a
// single read and a single write port: each slot is read, then updated.
// First-come and priority schedules read and update the chosen slot again
// after the walk. In priority mode every runnable slot that has been
// dispatched before and has a nonzero run or sleep count also runs the
// four-step niceness divider before its update. A new action is accepted as
// soon as the previous one is handed to the output register, even if that
// result is still waiting to be taken. Configuration writes take effect at
// once and should be made only while no action is in flight.
module process_table_priority_scheduler_core #(
    parameter int NUM_SLOTS = ptps_pkg::NUM_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ptps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // action[2:0], slot_index[8:3], new_status[11:9], target_pid[42:12],
    // new_prio[49:43], zero pad[55:50]
    input  logic [ptps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // ok[0], chosen_slot[6:1], chosen_pid[37:7], prev_prio[44:38],
    // yield_request[45], zero pad[47:46]
    output logic [ptps_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import ptps_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ptps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptps_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("new transaction accepted while an action is in flight");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("finished action did not reach the output register");

    a_one_mem_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.rd, cmd.rd_best, cmd.eval, cmd.pick, cmd.div_start}))
        else $error("conflicting slot memory commands");

endmodule
